// ===== design/two_finger_touch_frame_tracker_defines.svh =====
// Assertion helpers for the top module, the only file that asserts.
`ifndef TWO_FINGER_TOUCH_FRAME_TRACKER_DEFINES_SVH
`define TWO_FINGER_TOUCH_FRAME_TRACKER_DEFINES_SVH

// Clocked check, off while reset is held.
`define TFTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define TFTT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/tftt_pkg.sv =====
package tftt_pkg;

  typedef enum logic [1:0] {
    EV_CONTACT = 2'd0,
    EV_NOMELT  = 2'd1,
    EV_RECOVER = 2'd2,
    EV_SYNC    = 2'd3
  } event_kind_e;

  typedef enum logic [1:0] {
    MELT_IDLE   = 2'd0,
    MELT_SINGLE = 2'd1,
    MELT_MULTI  = 2'd2
  } melt_stage_e;

  typedef enum logic [2:0] {
    FC_FAULT,
    FC_BOTH,
    FC_ZERO,
    FC_ONE,
    FC_REL_MULTI,
    FC_REL_SINGLE,
    FC_IDLE
  } frame_case_e;

  localparam logic [1:0]  DevFault     = 2'd3;
  localparam logic [1:0]  FtcMax       = 2'd2;
  localparam logic [11:0] DragThreshRst = 12'd140;

  typedef struct packed {
    logic [3:0]  w;
    logic [11:0] x;
    logic [11:0] y;
  } finger_t;

  typedef struct packed {
    event_kind_e kind;
    logic        pressed;
    logic        sel_b;
  } slot_t;

  typedef struct packed {
    finger_t         fa;
    finger_t         fb;
    slot_t [2:0]     slot;
    logic  [1:0]     last_slot;
  } plan_t;

endpackage

// ===== design/tftt_in_if.sv =====
interface tftt_in_if;
  logic       valid;
  logic       ready;
  logic       read_failed;
  logic [1:0] chip_status;
  logic [3:0] finger_mask;
  logic [7:0] x_high_a;
  logic [7:0] y_high_a;
  logic [7:0] xy_low_a;
  logic [7:0] width_raw_a;
  logic [7:0] x_high_b;
  logic [7:0] y_high_b;
  logic [7:0] xy_low_b;
  logic [7:0] width_raw_b;

  modport source (
    output valid, read_failed, chip_status, finger_mask,
           x_high_a, y_high_a, xy_low_a, width_raw_a,
           x_high_b, y_high_b, xy_low_b, width_raw_b,
    input  ready
  );
  modport sink (
    input  valid, read_failed, chip_status, finger_mask,
           x_high_a, y_high_a, xy_low_a, width_raw_a,
           x_high_b, y_high_b, xy_low_b, width_raw_b,
    output ready
  );
endinterface

// ===== design/tftt_cfg_if.sv =====
interface tftt_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== design/tftt_out_if.sv =====
interface tftt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic        pressed;
  logic [3:0]  contact_width;
  logic [11:0] x_pos;
  logic [11:0] y_pos;
  logic        last;

  modport source (
    output valid, event_kind, pressed, contact_width, x_pos, y_pos, last,
    input  ready
  );
  modport sink (
    input  valid, event_kind, pressed, contact_width, x_pos, y_pos, last,
    output ready
  );
endinterface

// ===== design/two_finger_touch_frame_tracker.sv =====
// channel | dir | carries
// in_i    | in  | one register frame per item
// cfg_i   | in  | drag_threshold write, always ready
// out_o   | out | one event per item, last marks the end of a frame
//
// A frame is classified and the tracking state updated on the cycle it is taken.
// The back end sends one event per cycle while out_o is ready, so a frame yields 1 to 3 events.
// A frame's plan passes through the plan queue and the current-plan register to the output register.
// in_i stalls only when the plan queue is full; out_o stalls hold the output register.
// Reset clears all tracking state; drag_threshold returns to 140.
module two_finger_touch_frame_tracker import tftt_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tftt_in_if.sink    in_i,
  tftt_cfg_if.sink   cfg_i,
  tftt_out_if.source out_o
);

  `include "two_finger_touch_frame_tracker_defines.svh"

  logic  q_push, q_full, q_pop, q_empty;
  plan_t push_plan, head_plan;

  tftt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .plan_o   (push_plan)
  );

  tftt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_plan),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (head_plan)
  );

  tftt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .plan_i    (head_plan),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  `TFTT_ASSERT(a_last_kind, out_o.valid |-> (out_o.last == (out_o.event_kind == EV_SYNC || out_o.event_kind == EV_RECOVER)), "last flag does not match event kind")
  `TFTT_ASSERT(a_noncontact_zero, (out_o.valid && out_o.event_kind != EV_CONTACT) |-> (out_o.x_pos == 12'd0 && out_o.y_pos == 12'd0 && !out_o.pressed && out_o.contact_width == 4'd0), "non-contact item carries payload")
  `TFTT_ASSERT_RST(a_rst_quiet, !rst_ni |=> !out_o.valid, "output valid after reset")

endmodule

// ===== design/tftt_front.sv =====
module tftt_front import tftt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tftt_in_if.sink   in_i,
  tftt_cfg_if.sink  cfg_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output plan_t     plan_o
);

  function automatic finger_t decode_finger(input logic [7:0] xh, input logic [7:0] yh,
                                            input logic [7:0] xyl, input logic [7:0] wr);
    finger_t f;
    f.x = {xh, xyl[3:0]};
    f.y = {yh, xyl[7:4]};
    f.w = (wr[7:4] > wr[3:0]) ? wr[7:4] : wr[3:0];
    return f;
  endfunction

  function automatic slot_t mk_slot(input event_kind_e k, input logic pr, input logic sel);
    slot_t s;
    s.kind    = k;
    s.pressed = pr;
    s.sel_b   = sel;
    return s;
  endfunction

  logic [11:0] thr_q;
  logic        touch_q, touch_d;
  logic        multi_q, multi_d;
  logic        melt_en_q, melt_en_d;
  melt_stage_e stage_q, stage_d;
  logic [1:0]  ftc_q, ftc_d;
  logic [11:0] sx_q, sx_d, sy_q, sy_d;

  finger_t     fa, fb;
  logic        f0, f1, acc, drag_hit;
  logic [11:0] dx, dy;
  frame_case_e fcase;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !q_full_i;
  assign acc         = in_i.valid && in_i.ready;
  assign q_push_o    = acc;

  assign fa = decode_finger(in_i.x_high_a, in_i.y_high_a, in_i.xy_low_a, in_i.width_raw_a);
  assign fb = decode_finger(in_i.x_high_b, in_i.y_high_b, in_i.xy_low_b, in_i.width_raw_b);
  assign f0 = |in_i.finger_mask[1:0];
  assign f1 = |in_i.finger_mask[3:2];

  assign dx = (fa.x >= sx_q) ? fa.x - sx_q : sx_q - fa.x;
  assign dy = (fa.y >= sy_q) ? fa.y - sy_q : sy_q - fa.y;
  assign drag_hit = melt_en_q && (stage_q == MELT_SINGLE) && ((dx > thr_q) || (dy > thr_q));

  always_comb begin
    if (in_i.read_failed || in_i.chip_status == DevFault) begin
      fcase = FC_FAULT;
    end else if (f0 && f1) begin
      fcase = FC_BOTH;
    end else if (f0) begin
      fcase = FC_ZERO;
    end else if (f1) begin
      fcase = FC_ONE;
    end else if (multi_q && touch_q) begin
      fcase = FC_REL_MULTI;
    end else if (touch_q) begin
      fcase = FC_REL_SINGLE;
    end else begin
      fcase = FC_IDLE;
    end
  end

  // next state
  always_comb begin
    touch_d   = touch_q;
    multi_d   = multi_q;
    melt_en_d = melt_en_q;
    stage_d   = stage_q;
    ftc_d     = ftc_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    case (fcase)
      FC_FAULT: begin
        melt_en_d = 1'b1;
      end
      FC_BOTH: begin
        touch_d = 1'b1;
        multi_d = 1'b1;
        stage_d = MELT_MULTI;
      end
      FC_ZERO: begin
        if (ftc_q != FtcMax) ftc_d = ftc_q + 2'd1;
        touch_d = 1'b1;
        multi_d = 1'b0;
        if (stage_q == MELT_IDLE) stage_d = MELT_SINGLE;
        if (ftc_d == 2'd1) begin
          sx_d = fa.x;
          sy_d = fa.y;
        end
      end
      FC_ONE: begin
        multi_d = 1'b0;
      end
      FC_REL_MULTI: begin
        multi_d = 1'b0;
        touch_d = 1'b0;
        ftc_d   = 2'd0;
      end
      FC_REL_SINGLE: begin
        touch_d = 1'b0;
        ftc_d   = 2'd0;
        if (drag_hit) melt_en_d = 1'b0;
        stage_d = MELT_IDLE;
      end
      default: begin
      end
    endcase
  end

  // result plan
  always_comb begin
    plan_o.fa        = fa;
    plan_o.fb        = fb;
    plan_o.slot[0]   = mk_slot(EV_SYNC, 1'b0, 1'b0);
    plan_o.slot[1]   = mk_slot(EV_SYNC, 1'b0, 1'b0);
    plan_o.slot[2]   = mk_slot(EV_SYNC, 1'b0, 1'b0);
    plan_o.last_slot = 2'd0;
    case (fcase)
      FC_FAULT: begin
        plan_o.slot[0] = mk_slot(EV_RECOVER, 1'b0, 1'b0);
      end
      FC_BOTH: begin
        plan_o.slot[0]   = mk_slot(EV_CONTACT, 1'b1, 1'b0);
        plan_o.slot[1]   = mk_slot(EV_CONTACT, 1'b1, 1'b1);
        plan_o.last_slot = 2'd2;
      end
      FC_ZERO: begin
        plan_o.slot[0] = mk_slot(EV_CONTACT, 1'b1, 1'b0);
        if (multi_q) begin
          plan_o.slot[1]   = mk_slot(EV_CONTACT, 1'b0, 1'b1);
          plan_o.last_slot = 2'd2;
        end else begin
          plan_o.last_slot = 2'd1;
        end
      end
      FC_ONE: begin
        plan_o.slot[0] = mk_slot(EV_CONTACT, 1'b1, 1'b1);
        if (multi_q) begin
          plan_o.slot[1]   = mk_slot(EV_CONTACT, 1'b0, 1'b0);
          plan_o.last_slot = 2'd2;
        end else begin
          plan_o.last_slot = 2'd1;
        end
      end
      FC_REL_MULTI: begin
        plan_o.slot[0]   = mk_slot(EV_CONTACT, 1'b0, 1'b0);
        plan_o.slot[1]   = mk_slot(EV_CONTACT, 1'b0, 1'b1);
        plan_o.last_slot = 2'd2;
      end
      FC_REL_SINGLE: begin
        plan_o.slot[0] = mk_slot(EV_CONTACT, 1'b0, 1'b0);
        if (drag_hit) begin
          plan_o.slot[1]   = mk_slot(EV_NOMELT, 1'b0, 1'b0);
          plan_o.last_slot = 2'd2;
        end else begin
          plan_o.last_slot = 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= DragThreshRst;
      touch_q   <= 1'b0;
      multi_q   <= 1'b0;
      melt_en_q <= 1'b1;
      stage_q   <= MELT_IDLE;
      ftc_q     <= 2'd0;
      sx_q      <= 12'd0;
      sy_q      <= 12'd0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) thr_q <= cfg_i.data;
      if (acc) begin
        touch_q   <= touch_d;
        multi_q   <= multi_d;
        melt_en_q <= melt_en_d;
        stage_q   <= stage_d;
        ftc_q     <= ftc_d;
        sx_q      <= sx_d;
        sy_q      <= sy_d;
      end
    end
  end

endmodule

// ===== design/tftt_fifo.sv =====
module tftt_fifo import tftt_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  plan_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output plan_t data_o
);

  localparam int unsigned AW = $clog2(Depth);

  plan_t         mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/tftt_back.sv =====
module tftt_back import tftt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  plan_t      plan_i,
  output logic       q_pop_o,
  tftt_out_if.source out_o
);

  plan_t       cur_q, cur_d;
  logic        cur_valid_q, cur_valid_d;
  logic [1:0]  slot_q, slot_d;
  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic        pressed_q, last_q;
  logic [3:0]  w_q;
  logic [11:0] x_q, y_q;

  slot_t       s;
  finger_t     fin;
  logic        load, fin_slot;

  assign s        = cur_q.slot[slot_q];
  assign fin      = s.sel_b ? cur_q.fb : cur_q.fa;
  assign load     = cur_valid_q && (!out_valid_q || out_o.ready);
  assign fin_slot = load && (slot_q == cur_q.last_slot);
  assign q_pop_o  = !q_empty_i && (!cur_valid_q || fin_slot);

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    slot_d      = slot_q;
    if (q_pop_o) begin
      cur_d       = plan_i;
      cur_valid_d = 1'b1;
      slot_d      = 2'd0;
    end else if (fin_slot) begin
      cur_valid_d = 1'b0;
    end else if (load) begin
      slot_d = slot_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (load) begin
      kind_q <= s.kind;
      last_q <= (slot_q == cur_q.last_slot);
      if (s.kind == EV_CONTACT) begin
        pressed_q <= s.pressed;
        w_q       <= fin.w;
        x_q       <= fin.x;
        y_q       <= fin.y;
      end else begin
        pressed_q <= 1'b0;
        w_q       <= 4'd0;
        x_q       <= 12'd0;
        y_q       <= 12'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      slot_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      slot_q      <= slot_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_kind    = kind_q;
  assign out_o.pressed       = pressed_q;
  assign out_o.contact_width = w_q;
  assign out_o.x_pos         = x_q;
  assign out_o.y_pos         = y_q;
  assign out_o.last          = last_q;

endmodule

// ===== tb/sv/two_finger_touch_frame_tracker_tb.sv =====
module two_finger_touch_frame_tracker_tb;
  import tftt_pkg::*;

  typedef struct packed {
    logic       read_failed;
    logic [1:0] chip_status;
    logic [3:0] finger_mask;
    logic [7:0] x_high_a;
    logic [7:0] y_high_a;
    logic [7:0] xy_low_a;
    logic [7:0] width_raw_a;
    logic [7:0] x_high_b;
    logic [7:0] y_high_b;
    logic [7:0] xy_low_b;
    logic [7:0] width_raw_b;
  } touch_frame_t;

  typedef struct packed {
    event_kind_e kind;
    logic        pressed;
    logic [3:0]  w;
    logic [11:0] x;
    logic [11:0] y;
    logic        last;
  } touch_event_t;

  typedef struct {
    touch_frame_t       f;
    int                 n;
    touch_event_t [2:0] ev;
  } frame_row_t;

  localparam touch_event_t SyncEv    = '{kind: EV_SYNC, last: 1'b1, default: '0};
  localparam touch_event_t RecoverEv = '{kind: EV_RECOVER, last: 1'b1, default: '0};
  localparam touch_event_t CornerPressEv = '{kind: EV_CONTACT, pressed: 1'b1, w: 4'hF,
                                            x: 12'hFFF, y: 12'hFFF, last: 1'b0};

  logic clk_i;
  logic rst_ni;

  tftt_in_if  in_if ();
  tftt_cfg_if cfg_if ();
  tftt_out_if out_if ();

  two_finger_touch_frame_tracker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // tracker state mirror
  logic        touch_on;
  logic        multi_on;
  logic        melt_on;
  melt_stage_e melt_phase;
  logic [1:0]  touch_count;
  logic [11:0] anchor_x;
  logic [11:0] anchor_y;
  logic [11:0] drag_limit;

  touch_event_t       event_q[$];
  frame_row_t         frame_rows[$];
  int                 cur_ntyped;
  touch_event_t [2:0] cur_typed;
  int                 frames_sent;
  int                 events_seen;
  int                 mismatch_count;
  int unsigned        gap_pct;
  int unsigned        stall_pct;
  bit                 hold_req;
  bit                 hold_done;

  initial begin
    touch_on    = 1'b0;
    multi_on    = 1'b0;
    melt_on     = 1'b1;
    melt_phase  = MELT_IDLE;
    touch_count = '0;
    anchor_x    = '0;
    anchor_y    = '0;
    drag_limit  = DragThreshRst;
  end

  function automatic logic [3:0] wider_half(logic [7:0] raw);
    return (raw[7:4] > raw[3:0]) ? raw[7:4] : raw[3:0];
  endfunction

  function automatic logic [11:0] axis_gap(logic [11:0] a, logic [11:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void queue_event(event_kind_e k, logic p, logic [3:0] w,
                                      logic [11:0] x, logic [11:0] y, logic l);
    event_q.push_back('{kind: k, pressed: p, w: w, x: x, y: y, last: l});
  endfunction

  function automatic void predict_events(touch_frame_t f);
    logic [1:0]  f0, f1;
    logic [11:0] xa, ya, xb, yb;
    logic [3:0]  wa, wb;
    f0 = f.finger_mask[1:0];
    f1 = f.finger_mask[3:2];
    xa = {f.x_high_a, f.xy_low_a[3:0]};
    ya = {f.y_high_a, f.xy_low_a[7:4]};
    xb = {f.x_high_b, f.xy_low_b[3:0]};
    yb = {f.y_high_b, f.xy_low_b[7:4]};
    wa = wider_half(f.width_raw_a);
    wb = wider_half(f.width_raw_b);
    if (f.read_failed || f.chip_status == DevFault) begin
      melt_on = 1'b1;
      queue_event(EV_RECOVER, 1'b0, '0, '0, '0, 1'b1);
      return;
    end
    if (f0 != 0 && f1 != 0) begin
      touch_on   = 1'b1;
      multi_on   = 1'b1;
      melt_phase = MELT_MULTI;
      queue_event(EV_CONTACT, 1'b1, wa, xa, ya, 1'b0);
      queue_event(EV_CONTACT, 1'b1, wb, xb, yb, 1'b0);
    end else if (f0 != 0) begin
      if (touch_count < FtcMax) touch_count++;
      touch_on = 1'b1;
      if (melt_phase == MELT_IDLE) melt_phase = MELT_SINGLE;
      if (touch_count == 2'd1) begin
        anchor_x = xa;
        anchor_y = ya;
      end
      queue_event(EV_CONTACT, 1'b1, wa, xa, ya, 1'b0);
      if (multi_on) begin
        multi_on = 1'b0;
        queue_event(EV_CONTACT, 1'b0, wb, xb, yb, 1'b0);
      end
    end else if (f1 != 0) begin
      queue_event(EV_CONTACT, 1'b1, wb, xb, yb, 1'b0);
      if (multi_on) begin
        multi_on = 1'b0;
        queue_event(EV_CONTACT, 1'b0, wa, xa, ya, 1'b0);
      end
    end else if (multi_on && touch_on) begin
      multi_on    = 1'b0;
      touch_on    = 1'b0;
      touch_count = '0;
      queue_event(EV_CONTACT, 1'b0, wa, xa, ya, 1'b0);
      queue_event(EV_CONTACT, 1'b0, wb, xb, yb, 1'b0);
    end else if (touch_on) begin
      touch_on    = 1'b0;
      touch_count = '0;
      queue_event(EV_CONTACT, 1'b0, wa, xa, ya, 1'b0);
      if (melt_on && melt_phase == MELT_SINGLE &&
          (axis_gap(xa, anchor_x) > drag_limit || axis_gap(ya, anchor_y) > drag_limit)) begin
        queue_event(EV_NOMELT, 1'b0, '0, '0, '0, 1'b0);
        melt_on = 1'b0;
      end
      melt_phase = MELT_IDLE;
    end
    queue_event(EV_SYNC, 1'b0, '0, '0, '0, 1'b1);
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned got);
    if (exp != got) begin
      $error("%s: expected %0d, got %0d", name, exp, got);
      mismatch_count++;
    end
  endfunction

  function automatic touch_frame_t frame_of(logic rf, logic [1:0] st, logic [3:0] fs,
                                            logic [11:0] xa, logic [11:0] ya, logic [7:0] wa,
                                            logic [11:0] xb, logic [11:0] yb, logic [7:0] wb);
    touch_frame_t f;
    f.read_failed   = rf;
    f.chip_status   = st;
    f.finger_mask   = fs;
    f.x_high_a      = xa[11:4];
    f.y_high_a      = ya[11:4];
    f.xy_low_a      = {ya[3:0], xa[3:0]};
    f.width_raw_a   = wa;
    f.x_high_b      = xb[11:4];
    f.y_high_b      = yb[11:4];
    f.xy_low_b      = {yb[3:0], xb[3:0]};
    f.width_raw_b   = wb;
    return f;
  endfunction

  function automatic void add_row(touch_frame_t f, int n = 0, touch_event_t [2:0] ev = '0);
    frame_rows.push_back('{f: f, n: n, ev: ev});
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $error("timeout: %0d events still pending", event_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // checker: predicts on each frame taken, compares each event delivered
  always @(posedge clk_i) begin
    touch_event_t due;
    int base;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) drag_limit = cfg_if.data;
      if (in_if.valid && in_if.ready) begin
        base = event_q.size();
        predict_events({in_if.read_failed, in_if.chip_status, in_if.finger_mask,
                        in_if.x_high_a, in_if.y_high_a, in_if.xy_low_a, in_if.width_raw_a,
                        in_if.x_high_b, in_if.y_high_b, in_if.xy_low_b, in_if.width_raw_b});
        if (cur_ntyped != 0) begin
          while (event_q.size() > base) void'(event_q.pop_back());
          for (int i = 0; i < cur_ntyped; i++) event_q.push_back(cur_typed[i]);
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (event_q.size() == 0) begin
          $error("event kind %0d with no frame pending", out_if.event_kind);
          mismatch_count++;
        end else begin
          due = event_q.pop_front();
          events_seen++;
          check_field("event_kind", due.kind, out_if.event_kind);
          check_field("pressed", due.pressed, out_if.pressed);
          check_field("contact_width", due.w, out_if.contact_width);
          check_field("x_pos", due.x, out_if.x_pos);
          check_field("y_pos", due.y, out_if.y_pos);
          check_field("last", due.last, out_if.last);
        end
      end
    end
  end

  // output side: random stalls plus one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 299;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_frame(touch_frame_t f, int n_typed = 0, touch_event_t [2:0] typed = '0);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    {in_if.read_failed, in_if.chip_status, in_if.finger_mask,
     in_if.x_high_a, in_if.y_high_a, in_if.xy_low_a, in_if.width_raw_a,
     in_if.x_high_b, in_if.y_high_b, in_if.xy_low_b, in_if.width_raw_b} <= f;
    cur_ntyped <= n_typed;
    cur_typed  <= typed;
    do @(posedge clk_i); while (!in_if.ready);
    frames_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (event_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_drag_limit(logic [11:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic play_gesture();
    int          kind, frames, spread;
    logic [11:0] bx, by, px, py;
    logic [3:0]  fs;
    logic        rf;
    kind   = $urandom_range(99);
    frames = $urandom_range(1, 4);
    bx     = 12'($urandom);
    by     = 12'($urandom);
    spread = ($urandom_range(1) == 1) ? $urandom_range(200) : $urandom_range(2000);
    px     = bx;
    py     = by;
    if (kind < 85) begin
      for (int i = 0; i < frames; i++) begin
        px = bx + 12'($urandom_range(2 * spread) - spread);
        py = by + 12'($urandom_range(2 * spread) - spread);
        if (kind < 45) begin
          fs = {2'b00, 2'($urandom_range(1, 3))};
        end else if (kind < 75 && !(i == frames - 1 && $urandom_range(1) == 1)) begin
          fs = {2'($urandom_range(1, 3)), 2'($urandom_range(1, 3))};
        end else if (kind < 75) begin
          fs = ($urandom_range(1) == 1) ? {2'b00, 2'($urandom_range(1, 3))}
                                        : {2'($urandom_range(1, 3)), 2'b00};
        end else begin
          fs = {2'($urandom_range(1, 3)), 2'b00};
        end
        if ($urandom_range(99) < 6) begin
          rf = 1'($urandom_range(1));
          send_frame(frame_of(rf, rf ? 2'($urandom) : DevFault, fs, px, py, 8'($urandom),
                              12'($urandom), 12'($urandom), 8'($urandom)));
        end else begin
          send_frame(frame_of(1'b0, 2'($urandom_range(2)), fs, px, py, 8'($urandom),
                              12'($urandom), 12'($urandom), 8'($urandom)));
        end
      end
      send_frame(frame_of(1'b0, 2'($urandom_range(2)), 4'h0, px, py, 8'($urandom),
                          12'($urandom), 12'($urandom), 8'($urandom)));
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 2)) begin
        rf = 1'($urandom_range(1));
        send_frame(frame_of(rf, rf ? 2'($urandom) : DevFault, 4'($urandom), 12'($urandom),
                            12'($urandom), 8'($urandom), 12'($urandom), 12'($urandom),
                            8'($urandom)));
      end
    end else begin
      repeat (frames) send_frame(touch_frame_t'(71'({$urandom, $urandom, $urandom})));
    end
  endtask

  task automatic run_gestures(int count);
    int stop_at;
    stop_at = frames_sent + count;
    while (frames_sent < stop_at) play_gesture();
  endtask

  initial begin
    logic [11:0] mid_limit;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    {in_if.read_failed, in_if.chip_status, in_if.finger_mask,
     in_if.x_high_a, in_if.y_high_a, in_if.xy_low_a, in_if.width_raw_a,
     in_if.x_high_b, in_if.y_high_b, in_if.xy_low_b, in_if.width_raw_b} = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    cur_ntyped   = 0;
    cur_typed    = '0;
    gap_pct      = 7;
    stall_pct    = 57;

    // directed frames, drag limit at its reset value
    add_row(frame_of(1'b0, 2'd0, 4'h0, 12'h000, 12'h000, 8'h00, 12'h000, 12'h000, 8'h00),
            1, SyncEv);
    add_row(frame_of(1'b1, 2'd3, 4'hF, 12'hFFF, 12'hFFF, 8'hFF, 12'hFFF, 12'hFFF, 8'hFF),
            1, RecoverEv);
    add_row(frame_of(1'b0, 2'd3, 4'h3, 12'h123, 12'h456, 8'h5A, 12'h789, 12'hABC, 8'hA5),
            1, RecoverEv);
    add_row(frame_of(1'b1, 2'd0, 4'h0, 12'h000, 12'h000, 8'h00, 12'h000, 12'h000, 8'h00),
            1, RecoverEv);
    add_row(frame_of(1'b0, 2'd2, 4'h0, 12'h555, 12'hAAA, 8'h3C, 12'h0F0, 12'hF0F, 8'hC3),
            1, SyncEv);
    add_row(frame_of(1'b0, 2'd0, 4'hF, 12'hFFF, 12'hFFF, 8'hFF, 12'hFFF, 12'hFFF, 8'hFF), 3,
            {SyncEv, CornerPressEv, CornerPressEv});
    // one finger left after two: melt stays off the single-touch path
    add_row(frame_of(1'b0, 2'd1, 4'h1, 12'h000, 12'h000, 8'h0F, 12'h0AB, 12'h0CD, 8'hF0));
    add_row(frame_of(1'b0, 2'd0, 4'h0, 12'hFFF, 12'hFFF, 8'h00, 12'h000, 12'h000, 8'h00));
    // drag exactly at the limit, then one past it
    add_row(frame_of(1'b0, 2'd0, 4'h2, 12'h000, 12'h000, 8'hF0, 12'h111, 12'h222, 8'h12));
    add_row(frame_of(1'b0, 2'd1, 4'h2, 12'h800, 12'h800, 8'h37, 12'h333, 12'h444, 8'h73));
    add_row(frame_of(1'b0, 2'd2, 4'h0, 12'h08C, 12'h08C, 8'h21, 12'h555, 12'h666, 8'h00));
    add_row(frame_of(1'b0, 2'd0, 4'h3, 12'h100, 12'h100, 8'h44, 12'h777, 12'h888, 8'h99));
    add_row(frame_of(1'b0, 2'd0, 4'h0, 12'h18D, 12'h100, 8'h18, 12'h999, 12'hAAA, 8'h81));
    // melt already off: no command on a long drag
    add_row(frame_of(1'b0, 2'd0, 4'h2, 12'h000, 12'h000, 8'h66, 12'hBBB, 12'hCCC, 8'h00));
    add_row(frame_of(1'b0, 2'd0, 4'h0, 12'hFFF, 12'hFFF, 8'h00, 12'hDDD, 12'hEEE, 8'hFF));
    add_row(frame_of(1'b1, 2'd2, 4'h0, 12'h000, 12'h000, 8'h00, 12'h000, 12'h000, 8'h00),
            1, RecoverEv);
    // drag on the y axis only
    add_row(frame_of(1'b0, 2'd0, 4'h1, 12'hFFF, 12'hFFF, 8'h9E, 12'h010, 12'h020, 8'hE9));
    add_row(frame_of(1'b0, 2'd0, 4'h0, 12'hFFF, 12'hF72, 8'h11, 12'h030, 12'h040, 8'h22));
    // finger one alone from idle never arms the touch
    add_row(frame_of(1'b0, 2'd0, 4'hC, 12'h050, 12'h060, 8'h0A, 12'h321, 12'h654, 8'hB0));
    add_row(frame_of(1'b0, 2'd0, 4'h0, 12'h070, 12'h080, 8'h00, 12'h090, 12'h0A0, 8'h00),
            1, SyncEv);
    add_row(frame_of(1'b0, 2'd0, 4'hA, 12'h7FF, 12'h800, 8'h5F, 12'h801, 12'h7FE, 8'hF5));
    add_row(frame_of(1'b0, 2'd0, 4'h4, 12'h0B0, 12'h0C0, 8'h1C, 12'hFED, 12'hCBA, 8'hC1));
    add_row(frame_of(1'b0, 2'd0, 4'h8, 12'h0D0, 12'h0E0, 8'h2D, 12'hF00, 12'h00F, 8'hD2));
    add_row(frame_of(1'b0, 2'd0, 4'h5, 12'h001, 12'hFFE, 8'h3E, 12'hFFE, 12'h001, 8'hE3));
    add_row(frame_of(1'b0, 2'd0, 4'h0, 12'h246, 12'h8AC, 8'h4F, 12'h9BD, 12'h135, 8'hF4));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (frame_rows[i]) send_frame(frame_rows[i].f, frame_rows[i].n, frame_rows[i].ev);

    settle();
    write_drag_limit(12'd0);
    run_gestures(130);

    settle();
    gap_pct   = 57;
    stall_pct = 7;
    write_drag_limit(12'hFFF);
    run_gestures(130);

    settle();
    gap_pct   = 0;
    stall_pct = 0;
    mid_limit = 12'($urandom_range(20, 400));
    write_drag_limit(mid_limit);
    hold_req = 1'b1;
    run_gestures(130);

    settle();
    repeat (10) @(posedge clk_i);
    $display("%0d frames in, %0d events checked, %0d mismatches", frames_sent, events_seen,
             mismatch_count);
    $display("drag limits 140, 0, 4095, %0d; faults, one/two-finger gestures, noise, long stall",
             mid_limit);
    if (mismatch_count == 0 && event_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/tftt_pkg.sv
design/tftt_in_if.sv
design/tftt_cfg_if.sv
design/tftt_out_if.sv
design/tftt_front.sv
design/tftt_fifo.sv
design/tftt_back.sv
design/two_finger_touch_frame_tracker.sv
tb/sv/two_finger_touch_frame_tracker_tb.sv
